// ----- hw/rtl/bitmap_find_next_bit_unit_defines.svh -----
// Assertion macros shared by the bitmap search RTL.
`ifndef BITMAP_FIND_NEXT_BIT_UNIT_DEFINES_SVH
`define BITMAP_FIND_NEXT_BIT_UNIT_DEFINES_SVH

// Clocked property, disabled while in reset.
`define BFNB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same-cycle implication, disabled while in reset.
`define BFNB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

// ----- hw/rtl/bfnb_pkg.sv -----
// Types and constants of the bitmap search unit.
`timescale 1ns / 1ps

package bfnb_pkg;

  localparam int NumWords = 64;
  localparam int WordBits = 64;
  localparam int WIdxW    = (NumWords > 1) ? $clog2(NumWords) : 1;
  localparam int BitW     = $clog2(WordBits);
  localparam int SizeW    = 13;
  localparam int BaseW    = SizeW + 1;
  localparam int Capacity = NumWords * WordBits;
  localparam int AddrW    = 3;
  localparam int DataW    = 32;

  localparam logic [SizeW-1:0]    SizeReset  = 13'd4096;
  localparam logic [0:0]          RegIdxSize = 1'b0;
  localparam logic [WordBits-1:0] WordMask   = {WordBits{1'b1}};

  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,
    OP_FIND_SET = 2'd1,
    OP_FIND_CLR = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN,
    S_RESP
  } state_e;

endpackage

// ----- hw/rtl/bitmap_find_next_bit_unit.sv -----
// Bitmap store with find-next-set / find-next-clear search.
//
// Input words: operation_i selects write (word_index_i/word_data_i) or a
// search for the next set or clear bit at or above start_offset_i. Every
// input word gives exactly one output word (position_o, found_o).
// The unit holds one item at a time: in_stall_o is high from acceptance
// until the result has moved into the output register.
// A write, an unused code or an offset at/past the size goes straight
// from idle to the response state. A search reads one bitmap word per
// cycle from the single memory read port, starting at word 0 and stopping
// at the first match or the last word below the size. The next input
// word can be taken in the cycle after the output register loads.
// The output register decouples the receiver: while out_stall_i holds a
// result, the next item is still accepted and worked on, and it waits in
// the response state until the register frees up.
// Reset clears the control state and sets bitmap_size to 4096; bitmap
// words are undefined until written. bitmap_size sits at APB address 0.
`timescale 1ns / 1ps
`include "bitmap_find_next_bit_unit_defines.svh"

module bitmap_find_next_bit_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   operation_i,
  input  logic [5:0]                   word_index_i,
  input  logic [63:0]                  word_data_i,
  input  logic [bfnb_pkg::SizeW-1:0]   start_offset_i,
  // output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [bfnb_pkg::SizeW-1:0]   position_o,
  output logic                         found_o,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bfnb_pkg::AddrW-1:0]   paddr,
  input  logic [bfnb_pkg::DataW-1:0]   pwdata,
  output logic [bfnb_pkg::DataW-1:0]   prdata,
  output logic                         pready
);

  function automatic logic [bfnb_pkg::BitW-1:0] lowest_set(
    input logic [bfnb_pkg::WordBits-1:0] v
  );
    logic [bfnb_pkg::BitW-1:0] n;
    n = '0;
    for (int i = bfnb_pkg::WordBits - 1; i >= 0; i--) begin
      if (v[i]) n = bfnb_pkg::BitW'(i);
    end
    return n;
  endfunction

  bfnb_pkg::state_e state_q, state_d;
  bfnb_pkg::op_e    op;

  logic [bfnb_pkg::SizeW-1:0]    size_q, lim;
  logic [bfnb_pkg::BaseW-1:0]    lim_ext;
  logic                          cfg_we;

  logic [bfnb_pkg::WordBits-1:0] mem_q [bfnb_pkg::NumWords];
  logic [bfnb_pkg::WordBits-1:0] rdata_q;
  logic                          mem_we;
  logic [bfnb_pkg::WIdxW-1:0]    mem_wa;

  logic [bfnb_pkg::BaseW-1:0]    rd_base_q, rd_base_d;
  logic [bfnb_pkg::WIdxW-1:0]    rd_w_q, rd_w_d;
  logic                          chk_vld_q, chk_vld_d;
  logic [bfnb_pkg::BaseW-1:0]    chk_base_q, chk_base_d;
  logic [bfnb_pkg::SizeW-1:0]    off_q, off_d;
  logic                          zero_q, zero_d;
  logic [bfnb_pkg::BaseW-1:0]    hit_pos_q, hit_pos_d;
  logic [bfnb_pkg::SizeW-1:0]    res_pos_q, res_pos_d;
  logic                          res_found_q, res_found_d;
  logic                          out_valid_q, out_valid_d;
  logic [bfnb_pkg::SizeW-1:0]    position_q, position_d;
  logic                          found_q, found_d;

  logic                          in_acc, out_free, is_search, in_range, scan_end;
  logic [bfnb_pkg::BaseW-1:0]    chk_end, off_ext;
  logic [bfnb_pkg::BitW-1:0]     sh;
  logic [bfnb_pkg::WordBits-1:0] mask, v;
  logic                          hit;

  // ---- configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == bfnb_pkg::RegIdxSize);
  assign prdata = (paddr[2] == bfnb_pkg::RegIdxSize) ? bfnb_pkg::DataW'(size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= bfnb_pkg::SizeReset;
    end else if (cfg_we) begin
      size_q <= pwdata[bfnb_pkg::SizeW-1:0];
    end
  end

  // effective size saturates at the bitmap capacity
  assign lim     = (32'(size_q) >= bfnb_pkg::Capacity) ? bfnb_pkg::SizeW'(bfnb_pkg::Capacity)
                                                       : size_q;
  assign lim_ext = {1'b0, lim};

  // ---- handshakes
  assign op        = bfnb_pkg::op_e'(operation_i);
  assign in_stall_o = (state_q != bfnb_pkg::S_IDLE);
  assign in_acc    = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign is_search = (op == bfnb_pkg::OP_FIND_SET) || (op == bfnb_pkg::OP_FIND_CLR);
  assign in_range  = start_offset_i < lim;
  assign mem_wa    = bfnb_pkg::WIdxW'(32'(word_index_i));

  // ---- word check: mask bits below the offset, find lowest candidate
  assign off_ext = {1'b0, off_q};
  assign chk_end = chk_base_q + bfnb_pkg::BaseW'(bfnb_pkg::WordBits);

  always_comb begin
    sh   = '0;
    mask = bfnb_pkg::WordMask;
    if (chk_end <= off_ext) begin
      mask = '0;
    end else if (chk_base_q <= off_ext) begin
      sh   = bfnb_pkg::BitW'(off_ext - chk_base_q);
      mask = bfnb_pkg::WordMask << sh;
    end
  end

  assign v         = (zero_q ? ~rdata_q : rdata_q) & mask;
  assign hit       = chk_vld_q && (v != '0);
  assign hit_pos_d = chk_base_q + bfnb_pkg::BaseW'(lowest_set(v));
  assign scan_end  = !chk_vld_q && (rd_base_q >= lim_ext);

  // ---- next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bfnb_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = (is_search && in_range) ? bfnb_pkg::S_SCAN : bfnb_pkg::S_RESP;
        end
      end
      bfnb_pkg::S_SCAN: begin
        priority if (hit)  state_d = bfnb_pkg::S_FIN;
        else if (scan_end) state_d = bfnb_pkg::S_RESP;
        else               state_d = bfnb_pkg::S_SCAN;
      end
      bfnb_pkg::S_FIN: state_d = bfnb_pkg::S_RESP;
      bfnb_pkg::S_RESP: begin
        if (out_free) state_d = bfnb_pkg::S_IDLE;
      end
      default: state_d = bfnb_pkg::S_IDLE;
    endcase
  end

  // ---- datapath and outputs
  always_comb begin
    rd_base_d   = rd_base_q;
    rd_w_d      = rd_w_q;
    chk_vld_d   = chk_vld_q;
    chk_base_d  = chk_base_q;
    off_d       = off_q;
    zero_d      = zero_q;
    res_pos_d   = res_pos_q;
    res_found_d = res_found_q;
    position_d  = position_q;
    found_d     = found_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we      = 1'b0;

    unique case (state_q)
      bfnb_pkg::S_IDLE: begin
        if (in_acc) begin
          off_d       = start_offset_i;
          zero_d      = (op == bfnb_pkg::OP_FIND_CLR);
          rd_base_d   = '0;
          rd_w_d      = '0;
          chk_vld_d   = 1'b0;
          res_pos_d   = is_search ? lim : '0;
          res_found_d = 1'b0;
          mem_we      = (op == bfnb_pkg::OP_WRITE) &&
                        (32'(word_index_i) < bfnb_pkg::NumWords);
        end
      end
      bfnb_pkg::S_SCAN: begin
        // issue the next word read while checking the previous one
        if (rd_base_q < lim_ext) begin
          rd_base_d  = rd_base_q + bfnb_pkg::BaseW'(bfnb_pkg::WordBits);
          rd_w_d     = rd_w_q + 1'b1;
          chk_vld_d  = 1'b1;
          chk_base_d = rd_base_q;
        end else begin
          chk_vld_d  = 1'b0;
        end
        if (!hit && scan_end) begin
          res_pos_d   = lim;
          res_found_d = 1'b0;
        end
      end
      bfnb_pkg::S_FIN: begin
        // a match at or past the size in the last word counts as none
        if (hit_pos_q < lim_ext) begin
          res_pos_d   = hit_pos_q[bfnb_pkg::SizeW-1:0];
          res_found_d = 1'b1;
        end else begin
          res_pos_d   = lim;
          res_found_d = 1'b0;
        end
      end
      bfnb_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          position_d  = res_pos_q;
          found_d     = res_found_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign position_o  = position_q;
  assign found_o     = found_q;

  // ---- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bfnb_pkg::S_IDLE;
      chk_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chk_vld_q   <= chk_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_base_q   <= rd_base_d;
    rd_w_q      <= rd_w_d;
    chk_base_q  <= chk_base_d;
    off_q       <= off_d;
    zero_q      <= zero_d;
    hit_pos_q   <= hit_pos_d;
    res_pos_q   <= res_pos_d;
    res_found_q <= res_found_d;
    position_q  <= position_d;
    found_q     <= found_d;
  end

  // bitmap memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= word_data_i[bfnb_pkg::WordBits-1:0];
    end
    rdata_q <= mem_q[rd_w_q];
  end

  // ---- assertions
  `BFNB_ASSERT(a_accept_leaves_idle, (in_acc) |=> (state_q != bfnb_pkg::S_IDLE),
               "accepted word did not start work")
  `BFNB_ASSERT_IMP(a_found_below_size, (state_q == bfnb_pkg::S_RESP) && res_found_q,
                   res_pos_q < lim, "found position at or past size")
  `BFNB_ASSERT(a_rose_from_resp, $rose(out_valid_q) |-> $past(state_q == bfnb_pkg::S_RESP),
               "output loaded outside response state")
  `BFNB_ASSERT_IMP(a_read_in_range, (state_q == bfnb_pkg::S_SCAN) && (rd_base_q < lim_ext),
                   32'(rd_w_q) < bfnb_pkg::NumWords, "scan read beyond last word")

endmodule
